### rtl/gacp_pkg.sv
// Package with the types and constants of the AABB broad-phase pair finder.
package gacp_pkg;

   // Result kinds carried on the response tuser.
   localparam logic [1:0] STATUS_PAIR = 2'd0;
   localparam logic [1:0] STATUS_END  = 2'd1;
   localparam logic [1:0] STATUS_DROP = 2'd2;

   // At most this many pairs are reported for one box.
   localparam int unsigned MAX_PAIRS = 63;
   localparam int unsigned PAIR_CNT_W = 6;

   // Reset value of the cell shift register.
   localparam logic [3:0] CELL_SHIFT_RESET = 4'd9;

   // Widths of the stream payloads.
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 64;

   // One stored box.
   typedef struct packed {
      logic [14:0]        box_height;
      logic [14:0]        box_width;
      logic signed [15:0] y_pos;
      logic signed [15:0] x_pos;
      logic [31:0]        owner_id;
   } box_entry_type;

   // Control sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_STORE = 4'b0100,
      ST_MARK  = 4'b1000
   } state_type;

endpackage

### rtl/grid_aabb_collision_pairs.sv
// Top level of the grid-filtered AABB broad-phase pair finder.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata: id, x, y, w, h; tuser: first_of_frame
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: id_low, id_high; tuser: status; tlast
//  csr     | in        | csr_wr_en              | csr_wr_data: cell_shift
//
// A request is accepted, then each stored box is read from the box memory and tested in turn
// (its single read port sets the scan rate); the last entry read is tested, the box is appended
// and the marker is presented.
// A box that finds the store full goes straight to the marker.
// A stalled response holds the scan on the entry that produced the pending pair.
// Reset empties the store through its fill count, with no clearing pass, and sets cell_shift to 9.
module grid_aabb_collision_pairs
   import gacp_pkg::*;
#(
   parameter int unsigned MAX_BOXES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // owner_id[31:0], x_pos[47:32], y_pos[63:48], box_width[78:64], box_height[93:79]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // first_of_frame[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // id_low[31:0], id_high[63:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);

   localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int unsigned CW = $clog2(MAX_BOXES + 1);

   // Strict overlap of two intervals given as centre and size; the centres are doubled so the bounds stay whole.
   function automatic logic overlap_check(input logic signed [15:0] pa,
                                          input logic [14:0] sa,
                                          input logic signed [15:0] pb,
                                          input logic [14:0] sb);
      logic signed [17:0] a_lo;
      logic signed [17:0] a_hi;
      logic signed [17:0] b_lo;
      logic signed [17:0] b_hi;
      a_lo = {pa[15], pa, 1'b0} - {3'b000, sa};
      a_hi = {pa[15], pa, 1'b0} + {3'b000, sa};
      b_lo = {pb[15], pb, 1'b0} - {3'b000, sb};
      b_hi = {pb[15], pb, 1'b0} + {3'b000, sb};
      return (a_lo < b_hi) && (b_lo < a_hi);
   endfunction

   // Cell indices are within one of each other.
   function automatic logic near_check(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic [3:0] s);
      logic signed [15:0] ca;
      logic signed [15:0] cb;
      logic signed [16:0] d;
      ca = a >>> s;
      cb = b >>> s;
      d  = {ca[15], ca} - {cb[15], cb};
      return (d == 17'sd0) || (d == 17'sd1) || (d == -17'sd1);
   endfunction

   state_type               state_ff, state_in;
   logic [3:0]              cell_shift_ff, cell_shift_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           issue_ff, issue_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [PAIR_CNT_W-1:0]   pair_cnt_ff, pair_cnt_in;
   logic                    drop_ff, drop_in;
   box_entry_type           item_ff, item_in;
   box_entry_type           rd_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_lo_ff, rsp_lo_in;
   logic [31:0]             rsp_hi_ff, rsp_hi_in;
   logic                    rsp_last_ff, rsp_last_in;

   box_entry_type           box_mem [MAX_BOXES];
   logic                    mem_we;
   logic                    mem_re;
   logic                    req_accept;
   logic                    out_free;
   logic                    hit;
   logic                    hit_emit;
   logic [CW-1:0]           count_start;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Pair test against the entry that the memory just returned.
   assign hit = (rd_ff.owner_id != item_ff.owner_id)
             && near_check(item_ff.x_pos, rd_ff.x_pos, cell_shift_ff)
             && near_check(item_ff.y_pos, rd_ff.y_pos, cell_shift_ff)
             && overlap_check(item_ff.x_pos, item_ff.box_width, rd_ff.x_pos, rd_ff.box_width)
             && overlap_check(item_ff.y_pos, item_ff.box_height,
                              rd_ff.y_pos, rd_ff.box_height);
   assign hit_emit = rd_valid_ff && hit && (pair_cnt_ff != PAIR_CNT_W'(MAX_PAIRS));

   assign count_start = req_tuser ? '0 : count_ff;

   // Sequencer and response register next values.
   always_comb begin
      state_in      = state_ff;
      cell_shift_in = csr_wr_en ? csr_wr_data : cell_shift_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = rd_valid_ff;
      pair_cnt_in   = pair_cnt_ff;
      drop_in       = drop_ff;
      item_in       = item_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in     = box_entry_type'(req_tdata[93:0]);
               count_in    = count_start;
               issue_in    = '0;
               rd_valid_in = 1'b0;
               pair_cnt_in = '0;
               drop_in     = (count_start == CW'(MAX_BOXES));
               state_in    = (count_start == CW'(MAX_BOXES)) ? ST_MARK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Hold everything while a pair waits for the response register.
            if (!(hit_emit && !out_free)) begin
               if (hit_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_PAIR;
                  rsp_last_in   = 1'b0;
                  pair_cnt_in   = pair_cnt_ff + PAIR_CNT_W'(1);
                  if (item_ff.owner_id < rd_ff.owner_id) begin
                     rsp_lo_in = item_ff.owner_id;
                     rsp_hi_in = rd_ff.owner_id;
                  end else begin
                     rsp_lo_in = rd_ff.owner_id;
                     rsp_hi_in = item_ff.owner_id;
                  end
               end
               if (issue_ff < count_ff) begin
                  mem_re      = 1'b1;
                  issue_in    = issue_ff + CW'(1);
                  rd_valid_in = 1'b1;
               end else begin
                  rd_valid_in = 1'b0;
                  state_in    = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = drop_ff ? STATUS_DROP : STATUS_END;
               rsp_lo_in     = '0;
               rsp_hi_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cell_shift_ff <= CELL_SHIFT_RESET;
         count_ff      <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pair_cnt_ff   <= '0;
         drop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cell_shift_ff <= cell_shift_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         pair_cnt_ff   <= pair_cnt_in;
         drop_ff       <= drop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Box store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         box_mem[count_ff[AW-1:0]] <= item_ff;
      end
      if (mem_re) begin
         rd_ff <= box_mem[issue_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hi_ff, rsp_lo_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A box is only appended while the store has room.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (count_ff < CW'(MAX_BOXES)))
      else $error("box written to a full store");

   // The pair count never passes the per-request limit.
   assert property (@(posedge clock) disable iff (reset)
      pair_cnt_ff <= PAIR_CNT_W'(MAX_PAIRS))
      else $error("pair count above limit");

   // Closing markers and pairs are told apart by tlast and status alike.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_status_ff != STATUS_PAIR)))
      else $error("tlast does not match status");

   // A drop marker only follows a request that found the store full.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> !drop_ff)
      else $error("dropped box reached the store stage");

   // Once the marker is loaded the block is ready for the next request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) && out_free |=> req_tready && rsp_tvalid && rsp_tlast)
      else $error("marker not issued on leaving the marker state");

endmodule
